/* src/ccl_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cross-channel LRN package
// Shared constants, the configuration struct and the exp2 step table.
// ----------------------------------------------------------------------------
package ccl_pkg;

   localparam int MAX_WINDOW     = 16;
   localparam int SAMPLE_BITS    = 16;
   localparam int DELAY_DEPTH    = (MAX_WINDOW + 1) / 2;
   localparam int COUNT_PERIOD   = MAX_WINDOW * DELAY_DEPTH;
   localparam int WIN_IDX_BITS   = $clog2(MAX_WINDOW);
   localparam int DLY_IDX_BITS   = $clog2(DELAY_DEPTH);
   localparam int COUNT_BITS     = $clog2(2 * COUNT_PERIOD);
   localparam int SIZE_BITS      = 4;
   localparam int HALF_BITS      = SIZE_BITS - 1;
   localparam int MAG_BITS       = SAMPLE_BITS + 1;
   localparam int SQUARE_BITS    = 2 * SAMPLE_BITS;
   localparam int SUM_BITS       = 40;
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 24;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_WINDOW_SIZE = 2'd0,
      CSR_ALPHA       = 2'd1,
      CSR_BETA        = 2'd2,
      CSR_BIAS        = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [SIZE_BITS-1:0] window_size;
      logic [15:0]          alpha_over_size;
      logic [15:0]          beta_exponent;
      logic [23:0]          bias_k;
   } cfg_type;

   localparam logic [SIZE_BITS-1:0] RESET_WINDOW_SIZE = 4'd5;
   localparam logic [15:0]          RESET_ALPHA       = 16'd335;
   localparam logic [15:0]          RESET_BETA        = 16'd12288;
   localparam logic [23:0]          RESET_BIAS        = 24'd65536;

   // Magnitude of a signed sample, one bit wider so that the most negative
   // value is represented.
   function automatic logic [MAG_BITS-1:0] magnitude(input logic [SAMPLE_BITS-1:0] v);
      logic [MAG_BITS-1:0] ext;
      ext = {v[SAMPLE_BITS-1], v};
      return v[SAMPLE_BITS-1] ? (MAG_BITS'(0) - ext) : ext;
   endfunction

   function automatic logic [63:0] isqrt64(input logic [63:0] v_arg);
      logic [63:0] v;
      logic [63:0] r;
      logic [63:0] b;
      v = v_arg;
      r = '0;
      b = 64'd1 << 62;
      for (int k = 0; k < 32; k++) begin
         if (b > v) b = b >> 2;
      end
      for (int k = 0; k < 32; k++) begin
         if (b != 64'd0) begin
            if (v >= r + b) begin
               v = v - (r + b);
               r = (r >> 1) + b;
            end else begin
               r = r >> 1;
            end
            b = b >> 2;
         end
      end
      return r;
   endfunction

   // Entry j holds 2^(2^-(j+1)) in Q2.30, each one the square root of the
   // one before.
   function automatic logic [15:0][31:0] build_exp_tab();
      logic [15:0][31:0] tab;
      logic [63:0]       prev;
      prev   = isqrt64(64'd1 << 61);
      tab[0] = prev[31:0];
      for (int j = 1; j < 16; j++) begin
         prev   = isqrt64(prev << 30);
         tab[j] = prev[31:0];
      end
      return tab;
   endfunction

   localparam logic [15:0][31:0] EXP_TAB = build_exp_tab();

endpackage

/* src/ccl_req_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cross-channel LRN request interface
// Valid/ready channel that carries one input sample per transaction.
// ----------------------------------------------------------------------------
interface ccl_req_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [ccl_pkg::SAMPLE_BITS-1:0] sample_value;
   logic                                 sample_last;

   modport source (output valid, output sample_value, output sample_last, input ready);
   modport sink   (input valid, input sample_value, input sample_last, output ready);
endinterface

/* src/ccl_rsp_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cross-channel LRN response interface
// Valid/ready channel that carries one normalized sample per transaction.
// ----------------------------------------------------------------------------
interface ccl_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [ccl_pkg::SAMPLE_BITS-1:0] norm_value;
   logic                                 norm_last;

   modport source (output valid, output norm_value, output norm_last, input ready);
   modport sink   (input valid, input norm_value, input norm_last, output ready);
endinterface

/* src/cross_channel_lrn.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cross-channel local response normalization
// Streams one pixel's channel vector and returns each sample scaled by
// (k + alpha/size * sum of squares over its channel window)^-beta.
// ----------------------------------------------------------------------------
// Usage: req_stream carries one channel sample per transaction, sample_last
// marks the last channel of a pixel vector. rsp_stream returns one normalized
// sample per transaction, norm_last marking the last channel's result.
// Results trail the input by size/2 channels; the marked input releases the
// remaining results of the vector in channel order.
// The configuration port writes one register per cycle with csr_write_en;
// write it only while no transaction is in flight.
// Processing steps: an input that releases no result passes through accept,
// window sum update and finish. Each result it releases also passes through
// the normalization unit: a leading-one shift of up to 30 bit positions, 16
// squaring steps for log2 and 16 table multiplies for exp2. Results of the
// final flush each add a memory read and a sum update first, and a zero
// denominator skips log2/exp2.
// One input is handled at a time; req_stream.ready is high only between inputs.
// Reset (synchronous, active high) restores the register defaults and clears
// the running sum and channel count; the window memories need no clearing
// because only entries written in the current vector are ever read.
// When the receiver stalls, the finished result waits in the output register
// and the block holds before loading the next one.
// ----------------------------------------------------------------------------
module cross_channel_lrn (
   input  logic                               clock,
   input  logic                               reset,
   ccl_req_if.sink                            req_stream,
   ccl_rsp_if.source                          rsp_stream,
   input  logic                               csr_write_en,
   input  logic [ccl_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [ccl_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);

   localparam int CB = ccl_pkg::COUNT_BITS;
   localparam int SB = ccl_pkg::SAMPLE_BITS;

   typedef enum logic [3:0] {
      S_IDLE, S_SUM, S_NORM_START, S_NORM_WAIT, S_EMIT,
      S_FLUSH_INIT, S_FLUSH_READ, S_FLUSH_SUB, S_FINISH
   } state_type;

   ccl_pkg::cfg_type cfg;

   state_type                        state_ff;
   logic [CB-1:0]                    chan_ff;
   logic [CB-1:0]                    c_ff;
   logic [ccl_pkg::SUM_BITS-1:0]     sum_ff;
   logic [ccl_pkg::SQUARE_BITS-1:0]  sqr_ff;
   logic                             last_ff;
   logic                             flush_ff;
   logic                             emit_last_ff;
   logic [ccl_pkg::SIZE_BITS-1:0]    sz_ff;
   logic [ccl_pkg::HALF_BITS-1:0]    half_ff;
   logic [ccl_pkg::HALF_BITS-1:0]    head_ff;
   logic                             rsp_valid_ff;
   logic [SB-1:0]                    rsp_value_ff;
   logic                             rsp_last_ff;

   // Square and sample ring memories with registered reads.
   logic [ccl_pkg::SQUARE_BITS-1:0]  sq_mem [ccl_pkg::MAX_WINDOW];
   logic [SB-1:0]                    dly_mem [ccl_pkg::DELAY_DEPTH];
   logic [ccl_pkg::SQUARE_BITS-1:0]  sq_rdata_ff;
   logic [SB-1:0]                    dly_rdata_ff;

   logic                             accept;
   logic [ccl_pkg::SIZE_BITS-1:0]    sz_eff;
   logic [ccl_pkg::MAG_BITS-1:0]     in_mag;
   logic [2*ccl_pkg::MAG_BITS-1:0]   in_square;
   logic                             sq_re;
   logic [ccl_pkg::WIN_IDX_BITS-1:0] sq_raddr;
   logic                             dly_re;
   logic [ccl_pkg::DLY_IDX_BITS-1:0] dly_raddr;
   logic [CB-1:0]                    back_sz;
   logic [CB-1:0]                    back_half;
   logic [CB-1:0]                    back_head;
   logic [ccl_pkg::SUM_BITS:0]       sum_add;
   logic [CB:0]                      flush_start;
   logic [CB:0]                      chan_next;
   logic                             out_free;
   logic                             norm_start;
   logic                             norm_done;
   logic [SB-1:0]                    norm_result;

   ccl_csr_regs u_csr (
      .clock    (clock),
      .reset    (reset),
      .write_en (csr_write_en),
      .index    (csr_index),
      .wdata    (csr_wdata),
      .cfg      (cfg)
   );

   ccl_norm_unit u_norm (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .start      (norm_start),
      .sample     (dly_rdata_ff),
      .window_sum (sum_ff),
      .done       (norm_done),
      .result     (norm_result)
   );

   // A window size of zero acts as one; four bits never exceed the maximum.
   assign sz_eff    = (cfg.window_size == '0) ? ccl_pkg::SIZE_BITS'(1) : cfg.window_size;
   assign accept    = req_stream.valid && req_stream.ready;
   assign in_mag    = ccl_pkg::magnitude(req_stream.sample_value);
   assign in_square = in_mag * in_mag;
   assign back_sz   = chan_ff - CB'(sz_eff);
   assign back_half = chan_ff - CB'(half_ff);
   assign back_head = c_ff - CB'(head_ff) - CB'(1);
   assign sum_add   = {1'b0, sum_ff} + (ccl_pkg::SUM_BITS + 1)'(sqr_ff);
   assign flush_start = (chan_ff >= CB'(half_ff))
                        ? ({1'b0, chan_ff} - (CB + 1)'(half_ff) + (CB + 1)'(1))
                        : '0;
   assign chan_next = {1'b0, chan_ff} + (CB + 1)'(1);
   assign out_free  = !rsp_valid_ff || rsp_stream.ready;
   assign norm_start = (state_ff == S_NORM_START);

   always_comb begin
      sq_re     = 1'b0;
      sq_raddr  = back_sz[ccl_pkg::WIN_IDX_BITS-1:0];
      dly_re    = 1'b0;
      dly_raddr = back_half[ccl_pkg::DLY_IDX_BITS-1:0];
      case (state_ff)
         S_IDLE: begin
            sq_re = accept;
         end
         S_SUM: begin
            dly_re = 1'b1;
         end
         S_FLUSH_READ: begin
            sq_re     = 1'b1;
            sq_raddr  = back_head[ccl_pkg::WIN_IDX_BITS-1:0];
            dly_re    = 1'b1;
            dly_raddr = c_ff[ccl_pkg::DLY_IDX_BITS-1:0];
         end
         default: begin
            sq_re  = 1'b0;
            dly_re = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         sq_mem[chan_ff[ccl_pkg::WIN_IDX_BITS-1:0]]  <= in_square[ccl_pkg::SQUARE_BITS-1:0];
         dly_mem[chan_ff[ccl_pkg::DLY_IDX_BITS-1:0]] <= req_stream.sample_value;
      end
      if (sq_re) sq_rdata_ff <= sq_mem[sq_raddr];
      if (dly_re) dly_rdata_ff <= dly_mem[dly_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         chan_ff      <= '0;
         sum_ff       <= '0;
         flush_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // The emit step reloads the output register itself.
         if (rsp_valid_ff && rsp_stream.ready && state_ff != S_EMIT) rsp_valid_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  sqr_ff   <= in_square[ccl_pkg::SQUARE_BITS-1:0];
                  last_ff  <= req_stream.sample_last;
                  sz_ff    <= sz_eff;
                  half_ff  <= sz_eff[ccl_pkg::SIZE_BITS-1:1];
                  head_ff  <= ccl_pkg::HALF_BITS'((sz_eff - ccl_pkg::SIZE_BITS'(1)) >> 1);
                  flush_ff <= 1'b0;
                  state_ff <= S_SUM;
               end
            end
            S_SUM: begin
               // Add the new square and drop the one leaving the window.
               if (chan_ff >= CB'(sz_ff)) begin
                  sum_ff <= (sum_add > (ccl_pkg::SUM_BITS + 1)'(sq_rdata_ff))
                            ? ccl_pkg::SUM_BITS'(sum_add - (ccl_pkg::SUM_BITS + 1)'(sq_rdata_ff))
                            : '0;
               end else begin
                  sum_ff <= sum_add[ccl_pkg::SUM_BITS-1:0];
               end
               emit_last_ff <= last_ff && (half_ff == '0);
               if (chan_ff >= CB'(half_ff)) state_ff <= S_NORM_START;
               else if (last_ff) state_ff <= S_FLUSH_INIT;
               else state_ff <= S_FINISH;
            end
            S_NORM_START: begin
               state_ff <= S_NORM_WAIT;
            end
            S_NORM_WAIT: begin
               if (norm_done) state_ff <= S_EMIT;
            end
            S_EMIT: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_value_ff <= norm_result;
                  rsp_last_ff  <= emit_last_ff;
                  if (flush_ff) begin
                     if (c_ff == chan_ff) begin
                        state_ff <= S_FINISH;
                     end else begin
                        c_ff     <= c_ff + CB'(1);
                        state_ff <= S_FLUSH_READ;
                     end
                  end else if (last_ff) begin
                     state_ff <= S_FLUSH_INIT;
                  end else begin
                     state_ff <= S_FINISH;
                  end
               end
            end
            S_FLUSH_INIT: begin
               flush_ff <= 1'b1;
               c_ff     <= flush_start[CB-1:0];
               if (flush_start > {1'b0, chan_ff}) state_ff <= S_FINISH;
               else state_ff <= S_FLUSH_READ;
            end
            S_FLUSH_READ: begin
               state_ff <= S_FLUSH_SUB;
            end
            S_FLUSH_SUB: begin
               // The window's lower edge moves up while the upper edge is
               // clipped at the end of the vector.
               if (c_ff >= CB'(head_ff) + CB'(1)) begin
                  sum_ff <= (sum_ff > ccl_pkg::SUM_BITS'(sq_rdata_ff))
                            ? sum_ff - ccl_pkg::SUM_BITS'(sq_rdata_ff)
                            : '0;
               end
               emit_last_ff <= (c_ff == chan_ff);
               state_ff     <= S_NORM_START;
            end
            S_FINISH: begin
               flush_ff <= 1'b0;
               if (last_ff) begin
                  sum_ff  <= '0;
                  chan_ff <= '0;
               end else if (chan_next >= (CB + 1)'(2 * ccl_pkg::COUNT_PERIOD)) begin
                  chan_ff <= CB'(chan_next - (CB + 1)'(ccl_pkg::COUNT_PERIOD));
               end else begin
                  chan_ff <= chan_next[CB-1:0];
               end
               state_ff <= S_IDLE;
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign req_stream.ready      = (state_ff == S_IDLE);
   assign rsp_stream.valid      = rsp_valid_ff;
   assign rsp_stream.norm_value = rsp_value_ff;
   assign rsp_stream.norm_last  = rsp_last_ff;

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FINISH && last_ff) |=> (sum_ff == '0 && chan_ff == '0))
      else $error("vector end did not clear the window state");
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FLUSH_READ) |-> (c_ff <= chan_ff))
      else $error("flush ran past the last channel");
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_EMIT))
      else $error("result loaded outside the emit step");

endmodule

/* src/ccl_csr_regs.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cross-channel LRN configuration registers
// Write-only register file loaded from the plain write port.
// ----------------------------------------------------------------------------
module ccl_csr_regs (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               write_en,
   input  logic [ccl_pkg::CSR_INDEX_BITS-1:0] index,
   input  logic [ccl_pkg::CSR_DATA_BITS-1:0]  wdata,
   output ccl_pkg::cfg_type                   cfg
);

   ccl_pkg::cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.window_size     <= ccl_pkg::RESET_WINDOW_SIZE;
         cfg_ff.alpha_over_size <= ccl_pkg::RESET_ALPHA;
         cfg_ff.beta_exponent   <= ccl_pkg::RESET_BETA;
         cfg_ff.bias_k          <= ccl_pkg::RESET_BIAS;
      end else if (write_en) begin
         case (ccl_pkg::csr_index_type'(index))
            ccl_pkg::CSR_WINDOW_SIZE: begin
               cfg_ff.window_size <= wdata[ccl_pkg::SIZE_BITS-1:0];
            end
            ccl_pkg::CSR_ALPHA: begin
               cfg_ff.alpha_over_size <= wdata[15:0];
            end
            ccl_pkg::CSR_BETA: begin
               cfg_ff.beta_exponent <= wdata[15:0];
            end
            ccl_pkg::CSR_BIAS: begin
               cfg_ff.bias_k <= wdata[23:0];
            end
            default: begin
               cfg_ff <= cfg_ff;
            end
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule

/* src/ccl_norm_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cross-channel LRN normalization unit
// Iterative x * (k + alpha/size * sum)^-beta through a bitwise log2 and a
// table-driven exp2, one sample at a time.
// ----------------------------------------------------------------------------
module ccl_norm_unit (
   input  logic                                   clock,
   input  logic                                   reset,
   input  ccl_pkg::cfg_type                       cfg,
   input  logic                                   start,
   input  logic [ccl_pkg::SAMPLE_BITS-1:0]        sample,
   input  logic [ccl_pkg::SUM_BITS-1:0]           window_sum,
   output logic                                   done,
   output logic [ccl_pkg::SAMPLE_BITS-1:0]        result
);

   typedef enum logic [3:0] {
      N_IDLE, N_MUL, N_ADD, N_NORM, N_LOG, N_EXPMUL, N_EXP, N_FINAL, N_ROUND
   } nstate_type;

   localparam int SB = ccl_pkg::SAMPLE_BITS;

   nstate_type                  state_ff;
   logic [SB-1:0]               x_ff;
   logic [ccl_pkg::SUM_BITS-1:0] sum_ff;
   logic [47:0]                 plo_ff;
   logic [23:0]                 phi_ff;
   logic [30:0]                 m_ff;
   logic [4:0]                  p_ff;
   logic [15:0]                 frac_ff;
   logic [3:0]                  cnt_ff;
   logic signed [38:0]          eprod_ff;
   logic [31:0]                 g_ff;
   logic [ccl_pkg::MAG_BITS+31:0] prod_ff;
   logic                        zero_ff;
   logic                        done_ff;
   logic [SB-1:0]               result_ff;

   logic [25:0]                 denom;
   logic [61:0]                 sq_full;
   logic [31:0]                 sq_top;
   logic signed [5:0]           p_rel;
   logic signed [21:0]          log_val;
   logic signed [38:0]          beta_log;
   logic [63:0]                 gmul;
   logic                        f_bit;
   logic [ccl_pkg::MAG_BITS-1:0] mag;
   logic signed [8:0]           n_exp;
   logic signed [9:0]           s_shift;
   logic signed [9:0]           neg_shift;
   logic [5:0]                  shamt;
   logic [63:0]                 lim;
   logic [63:0]                 r_wide;
   logic [SB-1:0]               r_signed;

   assign denom   = {2'b00, cfg.bias_k} + {2'b00, phi_ff} + {10'd0, plo_ff[47:32]};
   assign sq_full = {31'd0, m_ff} * {31'd0, m_ff};
   assign sq_top  = sq_full[61:30];
   assign p_rel   = $signed({1'b0, p_ff}) - 6'sd16;
   assign log_val = {p_rel, frac_ff};
   assign beta_log = $signed({1'b0, cfg.beta_exponent}) * log_val;
   assign gmul    = {32'd0, g_ff} * {32'd0, ccl_pkg::EXP_TAB[cnt_ff]};
   assign f_bit   = eprod_ff[14 + 15 - cnt_ff];
   assign mag     = ccl_pkg::magnitude(x_ff);
   assign n_exp   = eprod_ff[38:30];
   assign s_shift = 10'sd30 - {n_exp[8], n_exp};
   assign neg_shift = -s_shift;
   assign lim     = x_ff[SB-1] ? (64'd1 << (SB - 1)) : ((64'd1 << (SB - 1)) - 64'd1);

   // Scale back by 2^(n-30) with round half up, then saturate.
   always_comb begin
      shamt  = '0;
      r_wide = '0;
      if (zero_ff) begin
         if (cfg.beta_exponent == 16'd0) r_wide = 64'(mag);
         else r_wide = (mag == '0) ? 64'd0 : lim;
      end else if (s_shift > 10'sd0) begin
         if (s_shift >= 10'sd50) begin
            r_wide = '0;
         end else begin
            shamt  = s_shift[5:0];
            r_wide = (64'(prod_ff) + (64'd1 << (shamt - 6'd1))) >> shamt;
         end
      end else if (prod_ff == '0) begin
         r_wide = '0;
      end else if (s_shift <= -10'sd16) begin
         r_wide = lim;
      end else begin
         shamt  = neg_shift[5:0];
         r_wide = 64'(prod_ff) << shamt;
      end
      if (r_wide > lim) r_wide = lim;
      r_signed = x_ff[SB-1] ? (SB'(0) - r_wide[SB-1:0]) : r_wide[SB-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= N_IDLE;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         case (state_ff)
            N_IDLE: begin
               if (start) begin
                  x_ff     <= sample;
                  sum_ff   <= window_sum;
                  state_ff <= N_MUL;
               end
            end
            N_MUL: begin
               plo_ff   <= cfg.alpha_over_size * sum_ff[31:0];
               phi_ff   <= cfg.alpha_over_size * sum_ff[39:32];
               state_ff <= N_ADD;
            end
            N_ADD: begin
               m_ff     <= {5'd0, denom};
               p_ff     <= 5'd30;
               frac_ff  <= '0;
               zero_ff  <= (denom == '0);
               state_ff <= (denom == '0) ? N_ROUND : N_NORM;
            end
            N_NORM: begin
               // One bit per cycle until the leading one sits at bit 30.
               if (m_ff[30]) begin
                  cnt_ff   <= 4'd15;
                  state_ff <= N_LOG;
               end else begin
                  m_ff <= m_ff << 1;
                  p_ff <= p_ff - 5'd1;
               end
            end
            N_LOG: begin
               frac_ff[cnt_ff] <= sq_top[31];
               m_ff <= sq_top[31] ? sq_top[31:1] : sq_top[30:0];
               if (cnt_ff == 4'd0) state_ff <= N_EXPMUL;
               else cnt_ff <= cnt_ff - 4'd1;
            end
            N_EXPMUL: begin
               eprod_ff <= -beta_log;
               g_ff     <= 32'd1 << 30;
               cnt_ff   <= '0;
               state_ff <= N_EXP;
            end
            N_EXP: begin
               if (f_bit) g_ff <= gmul[61:30];
               if (cnt_ff == 4'd15) state_ff <= N_FINAL;
               else cnt_ff <= cnt_ff + 4'd1;
            end
            N_FINAL: begin
               prod_ff  <= mag * g_ff;
               state_ff <= N_ROUND;
            end
            N_ROUND: begin
               result_ff <= r_signed;
               done_ff   <= 1'b1;
               state_ff  <= N_IDLE;
            end
            default: begin
               state_ff <= N_IDLE;
            end
         endcase
      end
   end

   assign done   = done_ff;
   assign result = result_ff;

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == N_LOG) |-> m_ff[30])
      else $error("log2 mantissa lost normalization");
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == N_EXP) |-> (g_ff[31] == 1'b0 && g_ff[30] == 1'b1))
      else $error("exp2 accumulator left [1,2)");
   assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(state_ff == N_ROUND))
      else $error("done raised outside rounding step");

endmodule

/* tb/tb_cross_channel_lrn.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cross-channel LRN testbench
// Streams pixel channel vectors through the block under a range of register
// settings and checks every normalized sample against a cycle-free predictor.
// ----------------------------------------------------------------------------
module tb_cross_channel_lrn;

   localparam int IDLE_LIMIT   = 6000;
   localparam int SETTLE_WAIT  = 150;
   localparam int PRESSURE_LEN = 500;

   typedef struct {
      logic signed [15:0] value;
      logic               last;
   } lrn_out_type;

   typedef struct {
      int                 cfg_id;
      logic signed [15:0] value;
      logic               last;
      bit                 known;
      logic signed [15:0] want;
   } stim_row_type;

   logic clock;
   logic reset;
   logic csr_write_en;
   logic [ccl_pkg::CSR_INDEX_BITS-1:0] csr_index;
   logic [ccl_pkg::CSR_DATA_BITS-1:0]  csr_wdata;

   ccl_req_if req_stream();
   ccl_rsp_if rsp_stream();

   cross_channel_lrn DUT (
      .clock        (clock),
      .reset        (reset),
      .req_stream   (req_stream.sink),
      .rsp_stream   (rsp_stream.source),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   // Predictor state: the register copy, the square ring, the sample delay
   // line, the running window sum and the channel position.
   ccl_pkg::cfg_type   model_cfg;
   logic [63:0]        square_ring [ccl_pkg::MAX_WINDOW];
   logic signed [15:0] sample_ring [ccl_pkg::DELAY_DEPTH];
   logic [63:0]        running_sum;
   int                 chan_pos;
   logic [63:0]        exp_step [1:16];

   lrn_out_type expected_norm [$];
   int          error_count;
   int          items_sent;
   int          results_seen;
   int          idle_cycles;
   bit          idle_free;
   bit          pressure_req;
   int          pressure_left;

   always #1 clock = ~clock;

   // Floor square root by bit-wise trial, used only to build the exp2 steps.
   function automatic logic [63:0] root_floor(input logic [63:0] v);
      logic [63:0] r;
      logic [63:0] c;
      r = '0;
      for (int b = 31; b >= 0; b--) begin
         c = r | (64'd1 << b);
         if (c * c <= v) r = c;
      end
      return r;
   endfunction

   // Normalized sample for value x and window sum: the denominator's log2 is
   // taken by repeated squaring, scaled by -beta, and raised back through
   // the exp2 steps; the product is rounded half up on the magnitude.
   function automatic logic [15:0] lrn_scale(input logic signed [15:0] x,
                                             input logic [63:0] sum);
      longint      xs;
      longint      l;
      logic [63:0] mag, lim, d, m, frac, t, u, g, prod, r;
      logic [63:0] alpha, beta;
      int          p, n, s;
      xs    = x;
      mag   = xs < 0 ? 64'(-xs) : 64'(xs);
      lim   = xs < 0 ? 64'd32768 : 64'd32767;
      alpha = 64'(model_cfg.alpha_over_size);
      beta  = 64'(model_cfg.beta_exponent);
      d = 64'(model_cfg.bias_k) + alpha * (sum >> 32)
          + ((alpha * (sum & 64'hFFFF_FFFF)) >> 32);
      if (d == 0) begin
         if (beta == 0) r = mag;
         else r = (mag == 0) ? 64'd0 : lim;
      end else begin
         p = 0;
         for (int i = 63; i >= 0; i--) begin
            if (d[i]) begin
               p = i;
               break;
            end
         end
         m = (p <= 30) ? (d << (30 - p)) : (d >> (p - 30));
         frac = '0;
         for (int i = 15; i >= 0; i--) begin
            m = (m * m) >> 30;
            if (m >= (64'd1 << 31)) begin
               frac[i] = 1'b1;
               m = m >> 1;
            end
         end
         l = longint'(p - 16) * 65536 + longint'(frac);
         t = 64'(-(longint'(beta) * l) + (longint'(1) << 40));
         u = (t >> 14) - (64'd1 << 26) + (64'd512 << 16);
         n = int'(u >> 16) - 512;
         g = 64'd1 << 30;
         for (int i = 1; i <= 16; i++) begin
            if (u[16 - i]) g = (g * exp_step[i]) >> 30;
         end
         prod = mag * g;
         s = 30 - n;
         if (s > 0) begin
            r = (s >= 63) ? 64'd0 : (prod + (64'd1 << (s - 1))) >> s;
         end else if (prod == 0) begin
            r = 0;
         end else if (-s >= 63 || prod > (lim >> -s)) begin
            r = lim;
         end else begin
            r = prod << -s;
         end
         if (r > lim) r = lim;
      end
      return xs < 0 ? 16'(-r) : 16'(r);
   endfunction

   function automatic logic [63:0] floor_sub(input logic [63:0] a, input logic [63:0] b);
      return a > b ? a - b : 64'd0;
   endfunction

   function automatic void queue_norm(input logic signed [15:0] x, input logic last);
      lrn_out_type e;
      e.value = lrn_scale(x, running_sum);
      e.last  = last;
      expected_norm.push_back(e);
   endfunction

   // Advances the predictor by one accepted sample and queues the results
   // it releases: at most one lagged result, plus the whole tail on the last channel.
   function automatic void predict_channel(input logic signed [15:0] x, input logic last);
      int          sz, half, head, start, nxt;
      logic [63:0] mag;
      sz = model_cfg.window_size;
      if (sz < 1) sz = 1;
      if (sz > ccl_pkg::MAX_WINDOW - 1) sz = ccl_pkg::MAX_WINDOW - 1;
      half = sz / 2;
      head = (sz - 1) / 2;
      mag  = x < 0 ? 64'(-longint'(x)) : 64'(x);
      square_ring[chan_pos % ccl_pkg::MAX_WINDOW] = mag * mag;
      sample_ring[chan_pos % ccl_pkg::DELAY_DEPTH] = x;
      running_sum = running_sum + mag * mag;
      if (chan_pos >= sz)
         running_sum = floor_sub(running_sum,
                                 square_ring[(chan_pos - sz) % ccl_pkg::MAX_WINDOW]);
      if (chan_pos >= half)
         queue_norm(sample_ring[(chan_pos - half) % ccl_pkg::DELAY_DEPTH],
                    last && half == 0);
      if (last) begin
         start = (chan_pos >= half) ? chan_pos - half + 1 : 0;
         for (int c = start; c <= chan_pos; c++) begin
            if (c >= head + 1)
               running_sum = floor_sub(running_sum,
                                       square_ring[(c - head - 1) % ccl_pkg::MAX_WINDOW]);
            queue_norm(sample_ring[c % ccl_pkg::DELAY_DEPTH], c == chan_pos);
         end
         running_sum = 0;
         chan_pos    = 0;
      end else begin
         nxt = chan_pos + 1;
         if (nxt >= 2 * ccl_pkg::COUNT_PERIOD) nxt -= ccl_pkg::COUNT_PERIOD;
         chan_pos = nxt;
      end
   endfunction

   task automatic report_mismatch(input string what);
      $display("MISMATCH at %0t: %s", $realtime, what);
      error_count++;
   endtask

   // Mostly short gaps, a few long ones, none at all in idle-free stretches.
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (idle_free || roll < 50) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic logic signed [15:0] pick_sample();
      int roll;
      roll = $urandom_range(0, 7);
      case (roll)
         0: begin
            return ($urandom_range(0, 1) != 0) ? 16'sh7FFF : 16'sh8000;
         end
         1, 2, 3: begin
            return 16'($signed($urandom_range(0, 4096)) - 2048);
         end
         default: begin
            return 16'($urandom);
         end
      endcase
   endfunction

   // Writes all four registers back to back; the block is idle here.
   task automatic write_config(input ccl_pkg::cfg_type cfg);
      csr_write_en <= 1'b1;
      csr_index    <= ccl_pkg::CSR_WINDOW_SIZE;
      csr_wdata    <= ccl_pkg::CSR_DATA_BITS'(cfg.window_size);
      @(posedge clock);
      csr_index    <= ccl_pkg::CSR_ALPHA;
      csr_wdata    <= ccl_pkg::CSR_DATA_BITS'(cfg.alpha_over_size);
      @(posedge clock);
      csr_index    <= ccl_pkg::CSR_BETA;
      csr_wdata    <= ccl_pkg::CSR_DATA_BITS'(cfg.beta_exponent);
      @(posedge clock);
      csr_index    <= ccl_pkg::CSR_BIAS;
      csr_wdata    <= cfg.bias_k;
      @(posedge clock);
      csr_write_en <= 1'b0;
      model_cfg = cfg;
   endtask

   // Lets the block finish all queued results, then waits out any work
   // still in flight from inputs that released nothing.
   task automatic drain_block();
      req_stream.valid <= 1'b0;
      while (expected_norm.size() != 0) @(posedge clock);
      repeat (SETTLE_WAIT) @(posedge clock);
   endtask

   // Offers one sample after a gap and returns at the accepting edge.
   // A known result is compared with the first expectation it released.
   task automatic send_sample(input logic signed [15:0] x, input logic last,
                              input bit known, input logic signed [15:0] want);
      int gap;
      int first;
      gap = pick_gap();
      if (gap > 0) begin
         req_stream.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_stream.valid        <= 1'b1;
      req_stream.sample_value <= x;
      req_stream.sample_last  <= last;
      @(posedge clock);
      while (!req_stream.ready) @(posedge clock);
      first = expected_norm.size();
      predict_channel(x, last);
      items_sent++;
      if (known && (expected_norm.size() <= first || expected_norm[first].value != want))
         report_mismatch($sformatf("predicted result for %0d is not the tabled %0d",
                                   x, want));
   endtask

   // Receiver: random stalls, and one long hold-off on request so that the
   // block backs up and stops taking input.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stream.ready <= 1'b0;
      end else if (pressure_left > 0) begin
         rsp_stream.ready <= 1'b0;
         pressure_left = pressure_left - 1;
      end else if (pressure_req) begin
         pressure_req = 1'b0;
         pressure_left = PRESSURE_LEN;
         rsp_stream.ready <= 1'b0;
      end else begin
         rsp_stream.ready <= (pick_gap() == 0);
      end
   end

   // Result checker: each accepted transaction against the oldest expectation.
   always @(posedge clock) begin
      lrn_out_type e;
      if (!reset && rsp_stream.valid && rsp_stream.ready) begin
         results_seen++;
         if (expected_norm.size() == 0) begin
            report_mismatch($sformatf("unexpected result %0d last %0b",
                                      rsp_stream.norm_value, rsp_stream.norm_last));
         end else begin
            e = expected_norm.pop_front();
            if (rsp_stream.norm_value !== e.value)
               report_mismatch($sformatf("norm_value %0d, expected %0d",
                                         rsp_stream.norm_value, e.value));
            if (rsp_stream.norm_last !== e.last)
               report_mismatch($sformatf("norm_last %0b, expected %0b",
                                         rsp_stream.norm_last, e.last));
         end
      end
   end

   // Watchdog: too long without any transaction on either side ends the run.
   always @(posedge clock) begin
      if (reset || (req_stream.valid && req_stream.ready)
          || (rsp_stream.valid && rsp_stream.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("Timeout: no transaction for %0d cycles", IDLE_LIMIT);
            $display("FAILED: results differ");
            $finish;
         end
      end
   end

   initial begin
      ccl_pkg::cfg_type phase_cfg [5];
      stim_row_type     rows [$];
      ccl_pkg::cfg_type cfg;
      int               cur_cfg;
      int               vec_len;
      int               phase_items;

      clock            = 1'b0;
      reset            = 1'b1;
      csr_write_en     = 1'b0;
      csr_index        = ccl_pkg::CSR_WINDOW_SIZE;
      csr_wdata        = '0;
      req_stream.valid = 1'b0;
      req_stream.sample_value = '0;
      req_stream.sample_last  = 1'b0;
      rsp_stream.ready = 1'b0;
      error_count      = 0;
      items_sent       = 0;
      results_seen     = 0;
      idle_cycles      = 0;
      idle_free        = 1'b0;
      pressure_req     = 1'b0;
      pressure_left    = 0;

      exp_step[1] = root_floor(64'd1 << 61);
      for (int i = 2; i <= 16; i++) exp_step[i] = root_floor(exp_step[i - 1] << 30);

      // The predictor starts from the reset state of the block.
      model_cfg = '{ccl_pkg::RESET_WINDOW_SIZE, ccl_pkg::RESET_ALPHA,
                    ccl_pkg::RESET_BETA, ccl_pkg::RESET_BIAS};
      foreach (square_ring[i]) square_ring[i] = '0;
      foreach (sample_ring[i]) sample_ring[i] = '0;
      running_sum = 0;
      chan_pos    = 0;

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Register sets for the directed part: reset values, a zero
      // denominator with and without beta, the widest and narrowest windows.
      phase_cfg[0] = model_cfg;
      phase_cfg[1] = '{4'd15, 16'd0, 16'd0, 24'd0};
      phase_cfg[2] = '{4'd0, 16'hFFFF, 16'hFFFF, 24'd0};
      phase_cfg[3] = '{4'd15, 16'hFFFF, 16'hFFFF, 24'hFFFFFF};
      phase_cfg[4] = '{4'd1, 16'd12345, 16'd1, 24'd1};

      rows = '{
         '{0, 16'sd0,      1'b1, 1'b1, 16'sd0},
         '{0, 16'sd32767,  1'b0, 1'b0, 16'sd0},
         '{0, -16'sd32768, 1'b0, 1'b0, 16'sd0},
         '{0, 16'sd4096,   1'b0, 1'b0, 16'sd0},
         '{0, -16'sd1,     1'b1, 1'b0, 16'sd0},
         '{0, 16'sd1,      1'b1, 1'b0, 16'sd0},
         '{1, 16'sd32767,  1'b1, 1'b1, 16'sd32767},
         '{1, -16'sd32768, 1'b1, 1'b1, -16'sd32768},
         '{1, 16'sd1234,   1'b0, 1'b0, 16'sd0},
         '{1, -16'sd77,    1'b1, 1'b0, 16'sd0},
         '{2, 16'sd5,      1'b1, 1'b1, 16'sd32767},
         '{2, -16'sd5,     1'b1, 1'b1, -16'sd32768},
         '{2, 16'sd0,      1'b1, 1'b1, 16'sd0},
         '{2, -16'sd32768, 1'b0, 1'b0, 16'sd0},
         '{2, 16'sd32767,  1'b1, 1'b0, 16'sd0},
         '{3, 16'sd32767,  1'b0, 1'b0, 16'sd0},
         '{3, -16'sd32768, 1'b0, 1'b0, 16'sd0},
         '{3, 16'sd100,    1'b0, 1'b0, 16'sd0},
         '{3, -16'sd100,   1'b1, 1'b0, 16'sd0},
         '{3, 16'sd16384,  1'b1, 1'b0, 16'sd0},
         '{4, -16'sd32768, 1'b0, 1'b0, 16'sd0},
         '{4, 16'sd32767,  1'b1, 1'b0, 16'sd0}
      };

      // Directed part: the table is walked in order, with the registers
      // rewritten whenever a row asks for another set.
      cur_cfg = 0;
      foreach (rows[r]) begin
         if (rows[r].cfg_id != cur_cfg) begin
            drain_block();
            cur_cfg = rows[r].cfg_id;
            write_config(phase_cfg[cur_cfg]);
         end
         send_sample(rows[r].value, rows[r].last, rows[r].known, rows[r].want);
      end

      // Random part: eight phases with fresh registers. Phase three is one
      // long vector that wraps the channel counter; the receiver backs off
      // once in phase one. A phase may stop mid-vector, so the next one
      // changes the window size inside a vector.
      for (int ph = 0; ph < 8; ph++) begin
         drain_block();
         cfg.window_size     = 4'($urandom_range(0, 15));
         cfg.alpha_over_size = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                            : 16'($urandom_range(0, 2000));
         cfg.beta_exponent   = 16'($urandom);
         case ($urandom_range(0, 3))
            0: cfg.bias_k = 24'd0;
            1: cfg.bias_k = 24'hFFFFFF;
            default: cfg.bias_k = 24'($urandom);
         endcase
         if (ph == 0) cfg = '{4'd15, 16'hFFFF, 16'hFFFF, 24'hFFFFFF};
         if (ph == 3) cfg = '{4'd7, 16'd335, 16'd12288, 24'd65536};
         write_config(cfg);
         idle_free = (ph % 3 == 2);
         if (ph == 1) pressure_req = 1'b1;
         if (ph == 3) begin
            for (int k = 0; k < 269; k++)
               send_sample(pick_sample(), k == 268, 1'b0, 16'sd0);
         end else begin
            phase_items = 0;
            while (phase_items < 24) begin
               vec_len = ($urandom_range(0, 4) == 0) ? $urandom_range(9, 24)
                                                     : $urandom_range(1, 8);
               for (int k = 0; k < vec_len && phase_items < 24; k++) begin
                  phase_items++;
                  send_sample(pick_sample(),
                              k == vec_len - 1 && !(ph % 2 == 1 && phase_items == 24),
                              1'b0, 16'sd0);
               end
            end
         end
      end
      idle_free = 1'b0;
      drain_block();

      $display("Covered %0d input samples and %0d normalized results over 5 directed",
               items_sent, results_seen);
      $display("and 8 random register sets, incl. a counter wrap and a long output stall.");
      if (error_count == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

/* filelist.f */
src/ccl_pkg.sv
src/ccl_req_if.sv
src/ccl_rsp_if.sv
src/ccl_csr_regs.sv
src/ccl_norm_unit.sv
src/cross_channel_lrn.sv
tb/tb_cross_channel_lrn.sv
